@@ src/jze_pkg.sv @@
package jze_pkg;

	// Default number of samples per channel in one round.
	localparam int unsigned SAMPLES_DEF = 12;

	localparam int unsigned SAMPLE_W = 10;
	localparam int unsigned COUNT_W  = 4;
	localparam int unsigned SUM_W    = 14;
	localparam int unsigned DIGIT_W  = 4;
	localparam int unsigned BOUND_W  = 12;

	// sum / 12 = (sum >> 2) / 3; the /3 is a multiply by ceil(2^13 / 3) and a shift.
	// Exact for every 12-bit dividend.
	localparam int unsigned DIV3_IN_W  = SUM_W - 2;
	localparam int unsigned DIV3_SHIFT = 13;
	localparam int unsigned DIV3_MUL   = 2731;
	localparam int unsigned PROD_W     = DIV3_IN_W + DIV3_SHIFT - 1;
	localparam int unsigned QUOT_W     = PROD_W - DIV3_SHIFT;
	localparam logic [SAMPLE_W-1:0] AVG_MAX = '1;

	typedef struct packed {
		logic                cmd;
		logic [SAMPLE_W-1:0] sample;
	} jze_in_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] first_digit;
		logic [DIGIT_W-1:0] second_digit;
		logic               active;
	} jze_out_t;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_BUTTON = 1'b1;

	typedef enum logic [1:0] {
		SLOT_SKIP,
		SLOT_AXIS_A,
		SLOT_AXIS_B
	} jze_slot_t;

	// Zone rule: alo < A < ahi and blo < B < bhi, all bounds exclusive.
	typedef struct packed {
		logic signed [BOUND_W-1:0] alo;
		logic signed [BOUND_W-1:0] ahi;
		logic signed [BOUND_W-1:0] blo;
		logic signed [BOUND_W-1:0] bhi;
		logic [DIGIT_W-1:0]        da;
		logic [DIGIT_W-1:0]        db;
	} jze_rule_t;

	localparam logic signed [BOUND_W-1:0] LO_NONE = -12'sd1;
	localparam logic signed [BOUND_W-1:0] HI_NONE = 12'sd1024;

	localparam int unsigned RULE_COUNT = 22;

	// Ordered: first match wins.
	localparam jze_rule_t ZONE_RULES [RULE_COUNT] = '{
		'{12'sd400, 12'sd600, 12'sd400, 12'sd600, 4'd5, 4'd5},
		'{12'sd600, 12'sd700, 12'sd400, 12'sd600, 4'd6, 4'd5},
		'{12'sd700, 12'sd800, 12'sd400, 12'sd600, 4'd7, 4'd5},
		'{12'sd800, 12'sd900, 12'sd400, 12'sd600, 4'd8, 4'd5},
		'{12'sd900, HI_NONE,  12'sd400, 12'sd600, 4'd9, 4'd5},
		'{12'sd400, 12'sd600, 12'sd600, 12'sd850, 4'd5, 4'd7},
		'{12'sd400, 12'sd600, 12'sd850, HI_NONE,  4'd5, 4'd9},
		'{12'sd400, 12'sd600, 12'sd250, 12'sd400, 4'd5, 4'd3},
		'{12'sd400, 12'sd600, LO_NONE,  12'sd250, 4'd5, 4'd1},
		'{12'sd250, 12'sd400, 12'sd400, 12'sd600, 4'd3, 4'd5},
		'{LO_NONE,  12'sd100, 12'sd400, 12'sd600, 4'd1, 4'd5},
		'{12'sd100, 12'sd200, 12'sd400, 12'sd600, 4'd2, 4'd5},
		'{12'sd200, 12'sd300, 12'sd400, 12'sd600, 4'd3, 4'd5},
		'{12'sd300, 12'sd400, 12'sd400, 12'sd600, 4'd4, 4'd5},
		'{12'sd600, 12'sd850, 12'sd600, 12'sd850, 4'd7, 4'd7},
		'{12'sd850, HI_NONE,  12'sd850, HI_NONE,  4'd9, 4'd9},
		'{12'sd250, 12'sd400, 12'sd600, 12'sd850, 4'd3, 4'd7},
		'{LO_NONE,  12'sd250, 12'sd850, HI_NONE,  4'd1, 4'd9},
		'{12'sd250, 12'sd400, 12'sd250, 12'sd400, 4'd3, 4'd3},
		'{LO_NONE,  12'sd250, LO_NONE,  12'sd250, 4'd1, 4'd1},
		'{12'sd600, 12'sd850, 12'sd250, 12'sd400, 4'd7, 4'd3},
		'{12'sd850, HI_NONE,  LO_NONE,  12'sd250, 4'd9, 4'd1}
	};

	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

endpackage

@@ src/joystick_zone_encoder.sv @@
// Joystick zone encoder.
//
// Input channel (req_valid / req_stall / req): one beat is either a converter
// sample (cmd = sample) or a button press (cmd = button). Samples arrive in
// rounds of three channels, SAMPLES beats per channel; each channel is
// averaged as sum / 12 (saturated to 1023). Channel 0 is discarded, channel 1
// is axis A, channel 2 is axis B. At the end of a round, while active, the
// ordered zone rules classify (A, B) into two digits; with no match the last
// digits are kept. Each round end emits one beat on the result channel
// (rsp_valid / rsp_stall / rsp). A button press toggles active, clears both
// digits and emits {0, 0, active}. Samples taken while paused are dropped.
//
// The input register takes the beat, and the result register loads from it
// when the beat advances; a result register held by rsp_stall can hold it.
// Throughput: one beat per cycle while req_stall is low; the input register feeds
// combinational accumulate, divide-by-12 and rule match into the result register.
// A stalled result holds the result register; beats that make no result
// still pass, and req_stall rises only while the beat in the input register
// must emit a result and the result register is still held by rsp_stall.
// Reset: round state cleared, digits 0, active = 1, no pending beats.
module joystick_zone_encoder #(
	parameter int unsigned SAMPLES = jze_pkg::SAMPLES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  jze_pkg::jze_in_t req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output jze_pkg::jze_out_t rsp
);

	// Round end count; SAMPLES = 16 wraps the 4-bit counter to zero.
	localparam logic [jze_pkg::COUNT_W-1:0] COUNT_END = jze_pkg::COUNT_W'(SAMPLES);

	// Input stage.
	logic             valid_s1;
	jze_pkg::jze_in_t item_s1;

	// Round and classifier state.
	jze_pkg::jze_slot_t                 slot_q;
	logic [jze_pkg::COUNT_W-1:0]        count_q;
	logic [jze_pkg::SUM_W-1:0]          sum_q;
	logic [jze_pkg::SAMPLE_W-1:0]       axis_a_q;
	logic [jze_pkg::DIGIT_W-1:0]        code_a_q;
	logic [jze_pkg::DIGIT_W-1:0]        code_b_q;
	logic                               running_q;

	// Result register.
	logic              out_valid_q;
	jze_pkg::jze_out_t out_q;

	// Datapath.
	logic                                is_button;
	logic [jze_pkg::SUM_W-1:0]           sum_next;
	logic [jze_pkg::COUNT_W-1:0]         count_next;
	logic                                round_chan_done;
	logic                                round_end;
	logic                                produces;
	logic                                out_free;
	logic                                advance;
	logic [jze_pkg::DIV3_IN_W-1:0]       div_in;
	logic [jze_pkg::PROD_W-1:0]          prod;
	logic [jze_pkg::QUOT_W-1:0]          quot;
	logic [jze_pkg::SAMPLE_W-1:0]        avg;
	logic signed [jze_pkg::BOUND_W-1:0]  a_s;
	logic signed [jze_pkg::BOUND_W-1:0]  b_s;
	logic [jze_pkg::RULE_COUNT-1:0]      hit;
	logic [jze_pkg::DIGIT_W-1:0]         new_a;
	logic [jze_pkg::DIGIT_W-1:0]         new_b;

	assign is_button       = (item_s1.cmd == jze_pkg::CMD_BUTTON);
	assign sum_next        = sum_q + jze_pkg::SUM_W'(item_s1.sample);
	assign count_next      = count_q + 1'b1;
	assign round_chan_done = (count_next == COUNT_END);

	// Slot 3 never occurs; it would end the round like the axis B slot.
	assign round_end = running_q && round_chan_done &&
		(slot_q != jze_pkg::SLOT_SKIP) && (slot_q != jze_pkg::SLOT_AXIS_A);

	assign produces  = is_button || round_end;
	assign out_free  = !out_valid_q || !rsp_stall;
	assign advance   = valid_s1 && (!produces || out_free);
	assign req_stall = valid_s1 && !advance;

	// sum / 12 via (sum >> 2) * 2731 >> 13, then saturate to 10 bits.
	assign div_in = sum_next[jze_pkg::SUM_W-1:2];
	assign prod   = jze_pkg::PROD_W'(div_in) * jze_pkg::PROD_W'(jze_pkg::DIV3_MUL);
	assign quot   = prod[jze_pkg::PROD_W-1:jze_pkg::DIV3_SHIFT];
	assign avg    = (quot > jze_pkg::QUOT_W'(jze_pkg::AVG_MAX)) ? jze_pkg::AVG_MAX
		: quot[jze_pkg::SAMPLE_W-1:0];

	assign a_s = $signed({2'b00, axis_a_q});
	assign b_s = $signed({2'b00, avg});

	// Zone match, lowest-numbered rule takes priority.
	always_comb begin
		for (int k = 0; k < jze_pkg::RULE_COUNT; k++) begin
			hit[k] = (a_s > jze_pkg::ZONE_RULES[k].alo) && (a_s < jze_pkg::ZONE_RULES[k].ahi) &&
				(b_s > jze_pkg::ZONE_RULES[k].blo) && (b_s < jze_pkg::ZONE_RULES[k].bhi);
		end
		new_a = code_a_q;
		new_b = code_b_q;
		for (int k = jze_pkg::RULE_COUNT - 1; k >= 0; k--) begin
			if (hit[k]) begin
				new_a = jze_pkg::ZONE_RULES[k].da;
				new_b = jze_pkg::ZONE_RULES[k].db;
			end
		end
	end

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			item_s1 <= req;
		end
	end

	// Round state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= jze_pkg::SLOT_SKIP;
			count_q   <= '0;
			sum_q     <= '0;
			axis_a_q  <= '0;
			code_a_q  <= '0;
			code_b_q  <= '0;
			running_q <= 1'b1;
		end else if (advance) begin
			if (is_button) begin
				running_q <= ~running_q;
				code_a_q  <= '0;
				code_b_q  <= '0;
			end else if (running_q) begin
				if (round_chan_done) begin
					sum_q   <= '0;
					count_q <= '0;
					case (slot_q)
						jze_pkg::SLOT_SKIP: begin
							slot_q <= jze_pkg::SLOT_AXIS_A;
						end
						jze_pkg::SLOT_AXIS_A: begin
							axis_a_q <= avg;
							slot_q   <= jze_pkg::SLOT_AXIS_B;
						end
						default: begin
							slot_q   <= jze_pkg::SLOT_SKIP;
							code_a_q <= new_a;
							code_b_q <= new_b;
						end
					endcase
				end else begin
					sum_q   <= sum_next;
					count_q <= count_next;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && produces;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produces) begin
			if (is_button) begin
				out_q.first_digit  <= '0;
				out_q.second_digit <= '0;
				out_q.active       <= ~running_q;
			end else begin
				out_q.first_digit  <= new_a;
				out_q.second_digit <= new_b;
				out_q.active       <= running_q;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// A button beat yields cleared digits and the new active flag.
	a_button_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_button) |=> (rsp_valid && rsp.first_digit == '0 &&
			rsp.second_digit == '0 && rsp.active == running_q))
		else $error("button result mismatch");

	// Emitted digits stay in the zone range.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.first_digit <= jze_pkg::DIGIT_MAX &&
			rsp.second_digit <= jze_pkg::DIGIT_MAX))
		else $error("digit out of range");

	// A beat that makes no result never blocks the input.
	a_no_result_flows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !produces) |-> !req_stall)
		else $error("silent beat stalled");

	// The round counter resets whenever a channel completes.
	a_count_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !is_button && running_q && round_chan_done) |=> (count_q == '0))
		else $error("sample count not cleared");

endmodule

@@ test/joystick_zone_encoder_tb.sv @@
`timescale 1ns / 1ps

module joystick_zone_encoder_tb;

	// Samples per channel; the block is built with its default.
	localparam int unsigned SAMPLES = jze_pkg::SAMPLES_DEF;
	localparam int DIVISOR = 12;
	localparam int AVG_CAP = 1023;
	localparam int ZONE_COUNT = 22;
	localparam int RANDOM_ITEMS = 600;
	localparam int RANDOM_ROUNDS_MIN = 20;
	localparam int DRAIN_LIMIT = 20000;

	// One zone: alo < A < ahi and blo < B < bhi, bounds exclusive, first match wins.
	typedef struct packed {
		int alo;
		int ahi;
		int blo;
		int bhi;
		int da;
		int db;
	} zone_t;

	localparam zone_t ZONES [ZONE_COUNT] = '{
		'{400, 600, 400, 600, 5, 5},
		'{600, 700, 400, 600, 6, 5},
		'{700, 800, 400, 600, 7, 5},
		'{800, 900, 400, 600, 8, 5},
		'{900, 1024, 400, 600, 9, 5},
		'{400, 600, 600, 850, 5, 7},
		'{400, 600, 850, 1024, 5, 9},
		'{400, 600, 250, 400, 5, 3},
		'{400, 600, -1, 250, 5, 1},
		'{250, 400, 400, 600, 3, 5},
		'{-1, 100, 400, 600, 1, 5},
		'{100, 200, 400, 600, 2, 5},
		'{200, 300, 400, 600, 3, 5},
		'{300, 400, 400, 600, 4, 5},
		'{600, 850, 600, 850, 7, 7},
		'{850, 1024, 850, 1024, 9, 9},
		'{250, 400, 600, 850, 3, 7},
		'{-1, 250, 850, 1024, 1, 9},
		'{250, 400, 250, 400, 3, 3},
		'{-1, 250, -1, 250, 1, 1},
		'{600, 850, 250, 400, 7, 3},
		'{850, 1024, -1, 250, 9, 1}
	};

	// Zone edges, used to aim random channel levels right at the thresholds.
	localparam int EDGE_COUNT = 10;
	localparam int EDGES [EDGE_COUNT] = '{100, 200, 250, 300, 400, 600, 700, 800, 850, 900};

	// Directed row: a button press, or a run of sample beats whose value follows
	// the channel the round is on (ch0/ch1/ch2). Where typed is set the result
	// of the row is the one written here.
	typedef struct packed {
		logic                           cmd;
		logic [5:0]                     beats;
		logic [jze_pkg::SAMPLE_W-1:0]   ch0;
		logic [jze_pkg::SAMPLE_W-1:0]   ch1;
		logic [jze_pkg::SAMPLE_W-1:0]   ch2;
		logic                           typed;
		logic [jze_pkg::DIGIT_W-1:0]    ea;
		logic [jze_pkg::DIGIT_W-1:0]    eb;
		logic                           eact;
	} dir_row_t;

	localparam int DIR_ROWS = 21;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// centered stick
		'{jze_pkg::CMD_SAMPLE, 6'd36, 10'd0,    10'd500,  10'd500,  1'b1, 4'd5, 4'd5, 1'b1},
		// all channels full scale, then all zero
		'{jze_pkg::CMD_SAMPLE, 6'd36, 10'd1023, 10'd1023, 10'd1023, 1'b1, 4'd9, 4'd9, 1'b1},
		'{jze_pkg::CMD_SAMPLE, 6'd36, 10'd0,    10'd0,    10'd0,    1'b1, 4'd1, 4'd1, 1'b1},
		// the 7,3 zone
		'{jze_pkg::CMD_SAMPLE, 6'd36, 10'd300,  10'd650,  10'd300,  1'b1, 4'd7, 4'd3, 1'b1},
		// sitting exactly on a boundary matches nothing: digits held
		'{jze_pkg::CMD_SAMPLE, 6'd36, 10'd0,    10'd600,  10'd600,  1'b1, 4'd7, 4'd3, 1'b1},
		'{jze_pkg::CMD_SAMPLE, 6'd36, 10'd1023, 10'd1023, 10'd0,    1'b1, 4'd9, 4'd1, 1'b1},
		'{jze_pkg::CMD_SAMPLE, 6'd36, 10'd0,    10'd851,  10'd849,  1'b0, 4'd0, 4'd0, 1'b0},
		'{jze_pkg::CMD_SAMPLE, 6'd36, 10'd512,  10'd50,   10'd500,  1'b0, 4'd0, 4'd0, 1'b0},
		'{jze_pkg::CMD_SAMPLE, 6'd36, 10'd0,    10'd401,  10'd599,  1'b0, 4'd0, 4'd0, 1'b0},
		'{jze_pkg::CMD_SAMPLE, 6'd36, 10'd0,    10'd300,  10'd700,  1'b0, 4'd0, 4'd0, 1'b0},
		'{jze_pkg::CMD_SAMPLE, 6'd36, 10'd0,    10'd250,  10'd250,  1'b0, 4'd0, 4'd0, 1'b0},
		'{jze_pkg::CMD_SAMPLE, 6'd36, 10'd777,  10'd899,  10'd101,  1'b0, 4'd0, 4'd0, 1'b0},
		// pause, then samples that must be dropped
		'{jze_pkg::CMD_BUTTON, 6'd1,  10'd0,    10'd0,    10'd0,    1'b1, 4'd0, 4'd0, 1'b0},
		'{jze_pkg::CMD_SAMPLE, 6'd1,  10'd1023, 10'd0,    10'd0,    1'b0, 4'd0, 4'd0, 1'b0},
		'{jze_pkg::CMD_SAMPLE, 6'd36, 10'd1023, 10'd0,    10'd1023, 1'b0, 4'd0, 4'd0, 1'b0},
		'{jze_pkg::CMD_BUTTON, 6'd1,  10'd0,    10'd0,    10'd0,    1'b1, 4'd0, 4'd0, 1'b1},
		// partial round survives a pause/resume
		'{jze_pkg::CMD_SAMPLE, 6'd1,  10'd1023, 10'd0,    10'd0,    1'b0, 4'd0, 4'd0, 1'b0},
		'{jze_pkg::CMD_BUTTON, 6'd1,  10'd0,    10'd0,    10'd0,    1'b1, 4'd0, 4'd0, 1'b0},
		'{jze_pkg::CMD_BUTTON, 6'd1,  10'd0,    10'd0,    10'd0,    1'b1, 4'd0, 4'd0, 1'b1},
		'{jze_pkg::CMD_SAMPLE, 6'd35, 10'd700,  10'd320,  10'd900,  1'b0, 4'd0, 4'd0, 1'b0},
		'{jze_pkg::CMD_SAMPLE, 6'd36, 10'd1023, 10'd599,  10'd401,  1'b0, 4'd0, 4'd0, 1'b0}
	};

	logic              clk;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	jze_pkg::jze_in_t  req = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	jze_pkg::jze_out_t rsp;

	// Idle / stall percentages, moved by the stimulus between phases.
	int send_idle_pct = 10;
	int stall_pct = 78;

	// Shadow of the block's state.
	jze_pkg::jze_slot_t           z_slot = jze_pkg::SLOT_SKIP;
	bit [jze_pkg::COUNT_W-1:0]    z_count = '0;
	bit [jze_pkg::SUM_W-1:0]      z_sum = '0;
	int                           z_axis_a = 0;
	bit [jze_pkg::DIGIT_W-1:0]    z_code_a = '0;
	bit [jze_pkg::DIGIT_W-1:0]    z_code_b = '0;
	bit                           z_active = 1'b1;

	jze_pkg::jze_out_t pending_codes [$];
	jze_pkg::jze_out_t want_codes;
	int                mismatches = 0;
	bit                in_random = 1'b0;
	int                rand_items = 0;
	int                rand_rounds = 0;

	joystick_zone_encoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the handshake hangs.
	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

	// Next zone digits for one accepted beat; updates the shadow state.
	task automatic zone_predict(input jze_pkg::jze_in_t b, output bit emit,
		output jze_pkg::jze_out_t res);
		int  avg;
		bit  hit;
		emit = 1'b0;
		res = '0;
		if (b.cmd == jze_pkg::CMD_BUTTON) begin
			// press: toggle, clear digits, partial round left alone
			z_active = !z_active;
			z_code_a = '0;
			z_code_b = '0;
			res.active = z_active;
			emit = 1'b1;
		end else if (z_active) begin
			z_sum = z_sum + jze_pkg::SUM_W'(b.sample);
			z_count = z_count + 1'b1;
			if (z_count == jze_pkg::COUNT_W'(SAMPLES)) begin
				avg = int'(z_sum) / DIVISOR;
				if (avg > AVG_CAP)
					avg = AVG_CAP;
				z_sum = '0;
				z_count = '0;
				case (z_slot)
				jze_pkg::SLOT_SKIP: begin
					z_slot = jze_pkg::SLOT_AXIS_A;
				end
				jze_pkg::SLOT_AXIS_A: begin
					z_axis_a = avg;
					z_slot = jze_pkg::SLOT_AXIS_B;
				end
				default: begin
					// round done: first matching zone wins, no match holds digits
					z_slot = jze_pkg::SLOT_SKIP;
					hit = 1'b0;
					for (int k = 0; k < ZONE_COUNT; k++) begin
						if (!hit && z_axis_a > ZONES[k].alo && z_axis_a < ZONES[k].ahi &&
							avg > ZONES[k].blo && avg < ZONES[k].bhi) begin
							z_code_a = jze_pkg::DIGIT_W'(ZONES[k].da);
							z_code_b = jze_pkg::DIGIT_W'(ZONES[k].db);
							hit = 1'b1;
						end
					end
					res.first_digit = z_code_a;
					res.second_digit = z_code_b;
					res.active = z_active;
					emit = 1'b1;
				end
				endcase
			end
		end
	endtask

	// Offer one beat, wait for it to be taken, then queue what it should produce.
	task automatic send_beat(input jze_pkg::jze_in_t b, input bit typed,
		input jze_pkg::jze_out_t typed_res, output bit emit);
		jze_pkg::jze_out_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= b;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		// dropped samples while paused do not count toward the random total
		if (in_random && !(b.cmd == jze_pkg::CMD_SAMPLE && !z_active))
			rand_items++;
		zone_predict(b, emit, res);
		if (emit) begin
			pending_codes.push_back(typed ? typed_res : res);
			if (in_random)
				rand_rounds++;
		end
	endtask

	// Result side: random stall, and compare each taken beat with the oldest expectation.
	always @(posedge clk)
		rsp_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_codes.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual %0d%0d active %0b",
					$time, rsp.first_digit, rsp.second_digit, rsp.active);
				mismatches++;
			end else begin
				want_codes = pending_codes.pop_front();
				if (rsp.first_digit !== want_codes.first_digit) begin
					$display("%0t: first_digit expected %0d actual %0d",
						$time, want_codes.first_digit, rsp.first_digit);
					mismatches++;
				end
				if (rsp.second_digit !== want_codes.second_digit) begin
					$display("%0t: second_digit expected %0d actual %0d",
						$time, want_codes.second_digit, rsp.second_digit);
					mismatches++;
				end
				if (rsp.active !== want_codes.active) begin
					$display("%0t: active expected %0b actual %0b",
						$time, want_codes.active, rsp.active);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		dir_row_t          row;
		jze_pkg::jze_in_t  beat_in;
		bit                emit;
		int                level [3];
		int                chan [3];
		int                spread;
		bit                wild;
		int                v;
		int                n;
		int                drain;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Sample values follow the shadow's current channel so
		// a row lines up with the round even after a partial one.
		for (int r = 0; r < DIR_ROWS; r++) begin
			row = DIRECTED[r];
			chan[0] = int'(row.ch0);
			chan[1] = int'(row.ch1);
			chan[2] = int'(row.ch2);
			if (row.cmd == jze_pkg::CMD_BUTTON) begin
				beat_in.cmd = jze_pkg::CMD_BUTTON;
				beat_in.sample = '0;
				send_beat(beat_in, row.typed, '{row.ea, row.eb, row.eact}, emit);
			end else begin
				for (int j = 0; j < row.beats; j++) begin
					beat_in.cmd = jze_pkg::CMD_SAMPLE;
					beat_in.sample = jze_pkg::SAMPLE_W'(chan[int'(z_slot)]);
					send_beat(beat_in, row.typed, '{row.ea, row.eb, row.eact}, emit);
				end
			end
		end

		// Random part: mostly whole rounds with each channel parked near a level,
		// plus pause/resume pairs and loose samples that break round alignment.
		in_random = 1'b1;
		while (rand_items < RANDOM_ITEMS || rand_rounds < RANDOM_ROUNDS_MIN) begin
			// receiver slow, then the reverse (sender slow), then full speed
			if (rand_items < RANDOM_ITEMS / 3) begin
				send_idle_pct = 10;
				stall_pct = 78;
			end else if (rand_items < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 78;
				stall_pct = 10;
			end else begin
				send_idle_pct = 0;
				stall_pct = 0;
			end

			n = $urandom_range(99);
			if (n < 80) begin
				for (int c = 0; c < 3; c++) begin
					case ($urandom_range(3))
					0: level[c] = EDGES[$urandom_range(EDGE_COUNT - 1)] +
						int'($urandom_range(4)) - 2;
					1: level[c] = $urandom_range(1023);
					2: level[c] = $urandom_range(1) ? 1023 : 0;
					default: level[c] = 400 + $urandom_range(200);
					endcase
				end
				case ($urandom_range(4))
				0, 1: spread = 0;
				2: spread = 3;
				default: spread = 40;
				endcase
				wild = ($urandom_range(9) == 0);
				// run until the round closes, wherever it started
				do begin
					if (wild)
						v = $urandom_range(1023);
					else
						v = level[int'(z_slot)] + int'($urandom_range(2 * spread)) - spread;
					if (v < 0)
						v = 0;
					if (v > 1023)
						v = 1023;
					beat_in.cmd = jze_pkg::CMD_SAMPLE;
					beat_in.sample = jze_pkg::SAMPLE_W'(v);
					send_beat(beat_in, 1'b0, '0, emit);
				end while (!emit);
			end else if (n < 90) begin
				// pause, a few dropped samples, resume
				beat_in.cmd = jze_pkg::CMD_BUTTON;
				beat_in.sample = jze_pkg::SAMPLE_W'($urandom_range(1023));
				send_beat(beat_in, 1'b0, '0, emit);
				repeat ($urandom_range(4)) begin
					beat_in.cmd = jze_pkg::CMD_SAMPLE;
					beat_in.sample = jze_pkg::SAMPLE_W'($urandom_range(1023));
					send_beat(beat_in, 1'b0, '0, emit);
				end
				beat_in.cmd = jze_pkg::CMD_BUTTON;
				beat_in.sample = jze_pkg::SAMPLE_W'($urandom_range(1023));
				send_beat(beat_in, 1'b0, '0, emit);
			end else begin
				repeat (1 + $urandom_range(14)) begin
					beat_in.cmd = jze_pkg::CMD_SAMPLE;
					beat_in.sample = jze_pkg::SAMPLE_W'($urandom_range(1023));
					send_beat(beat_in, 1'b0, '0, emit);
				end
			end
		end

		req_valid <= 1'b0;
		stall_pct = 0;

		// Drain: wait for all results back, then for anything stray.
		drain = 0;
		while (pending_codes.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);
		if (pending_codes.size() != 0) begin
			$display("%0t: %0d expected beats never arrived", $time, pending_codes.size());
			mismatches++;
		end

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
